### sv/chd_pkg.sv
// Shared types, constants and helper functions for the chunked body decoder.
`default_nettype none

package chd_pkg;

   localparam int MAX_LINE_CHARS = 15;
   localparam int SIZE_BITS      = 32;
   localparam int LINE_W         = $clog2(MAX_LINE_CHARS + 1);

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_UX    = 8'h58;

   localparam logic [LINE_W-1:0] LINE_MAX = LINE_W'(MAX_LINE_CHARS);

   typedef enum logic [2:0] {
      PH_LINE      = 3'd0,
      PH_DATA      = 3'd1,
      PH_SKIP_NEXT = 3'd2,
      PH_SKIP_END  = 3'd3,
      PH_DONE      = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      HX_SPACES = 2'd0,
      HX_ZERO   = 2'd1,
      HX_DIGITS = 2'd2,
      HX_DONE   = 2'd3
   } hex_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_END   = 2'd1,
      KIND_TRUNC = 2'd2
   } kind_type;

   typedef enum logic {
      OP_BYTE    = 1'b0,
      OP_TIMEOUT = 1'b1
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      kind_type   kind;
   } result_type;

   typedef struct packed {
      logic done;
   } status_type;

   // {is_hex, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h61 + 8'd10)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h41 + 8'd10)};
      return r;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
   endfunction

endpackage

`default_nettype wire

### sv/http_chunked_body_decoder.sv
// Top level of the HTTP chunked body decoder: input stage, core, result register.
//
//  channel   ports                                   direction
//  req       req_valid req_stall req_op req_rx_byte  in  (byte or timeout item)
//  rsp       rsp_valid rsp_stall rsp_data rsp_kind   out (data byte or end marker)
//  csr       csr_we csr_wdata                        in  (chunked_mode bit)
//
// One item per cycle sustained while the result is not stalled; an item's result
// shows on rsp_ from the result register, after the item has left the input stage.
// Each item is registered, decoded combinationally by the core, and its result
// (if any) lands in the result register. Items that give no result still
// pass through the core and update framing state.
// Synchronous active-high reset: empty pipe, plain mode, size-line phase.
// A stalled result holds both stages; req_stall rises only while the input
// stage is full and cannot move on.
`default_nettype none

module http_chunked_body_decoder
   import chd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_op,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_data,
   output logic [1:0]      rsp_kind,
   input  wire logic       csr_we,
   input  wire logic       csr_wdata
);

   // input stage
   logic       stg_valid_ff, stg_valid_in;
   item_type   stg_item_ff;

   // result register
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_data_ff;
   kind_type   out_kind_ff;

   logic       advance;
   logic       accept;
   logic       go;
   result_type res;
   status_type status;

   // the core may step whenever the result register can take a new item
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = stg_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign go        = stg_valid_ff && advance;

   always_comb begin
      if (accept) begin
         stg_valid_in = 1'b1;
      end else if (advance) begin
         stg_valid_in = 1'b0;
      end else begin
         stg_valid_in = stg_valid_ff;
      end

      if (go && res.valid) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         stg_item_ff <= '{op: op_type'(req_op), rx_byte: req_rx_byte};
      end
      if (go && res.valid) begin
         out_data_ff <= res.data;
         out_kind_ff <= res.kind;
      end
   end

   chd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .go        (go),
      .item      (stg_item_ff),
      .res       (res),
      .status    (status)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign rsp_kind  = out_kind_ff;

   // once the body has ended, nothing more comes out of the core
   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      status.done |-> !res.valid)
      else $error("core produced a result after end of body");

   // end markers carry a zero data byte
   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_DATA) |-> (rsp_data == 8'd0))
      else $error("end marker with nonzero data");

   // an empty input stage never pushes back
   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !stg_valid_ff |-> !req_stall)
      else $error("stall raised with empty input stage");

   // a stalled result stays in place, and the core does not step over it
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |-> !go)
      else $error("core stepped while result was stalled");

endmodule

`default_nettype wire

### sv/chd_core.sv
// Framing state and per-item decode logic of the chunked body decoder.
`default_nettype none

module chd_core
   import chd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_we,
   input  wire logic       csr_wdata,
   input  wire logic       go,
   input  wire item_type   item,
   output result_type      res,
   output status_type      status
);

   logic                  mode_ff;
   phase_type             phase_ff,  phase_in;
   logic [SIZE_BITS-1:0]  left_ff,   left_in;
   logic [SIZE_BITS-1:0]  accum_ff,  accum_in;
   logic [LINE_W-1:0]     chars_ff,  chars_in;
   hex_type               hx_ff,     hx_in;
   logic [1:0]            skip_ff,   skip_in;

   logic [4:0]            hd;
   logic [SIZE_BITS-1:0]  accum_add;
   logic [SIZE_BITS-1:0]  left_dec;
   logic [1:0]            skip_dec;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         phase_ff <= PH_LINE;
         left_ff  <= '0;
         accum_ff <= '0;
         chars_ff <= '0;
         hx_ff    <= HX_SPACES;
         skip_ff  <= 2'd0;
      end else begin
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
         phase_ff <= phase_in;
         left_ff  <= left_in;
         accum_ff <= accum_in;
         chars_ff <= chars_in;
         hx_ff    <= hx_in;
         skip_ff  <= skip_in;
      end
   end

   always_comb begin
      hd        = hex_digit(item.rx_byte);
      // saturate once the top nibble would shift out
      accum_add = (accum_ff[SIZE_BITS-1 -: 4] != 4'd0) ? '1
                : {accum_ff[SIZE_BITS-5:0], hd[3:0]};
      left_dec  = left_ff - SIZE_BITS'(1);
      skip_dec  = (skip_ff != 2'd0) ? skip_ff - 2'd1 : skip_ff;

      phase_in = phase_ff;
      left_in  = left_ff;
      accum_in = accum_ff;
      chars_in = chars_ff;
      hx_in    = hx_ff;
      skip_in  = skip_ff;
      res      = '{valid: 1'b0, data: 8'd0, kind: KIND_DATA};

      if (go && phase_ff != PH_DONE) begin
         if (!mode_ff) begin
            if (item.op == OP_TIMEOUT) begin
               phase_in = PH_DONE;
               res      = '{valid: 1'b1, data: 8'd0, kind: KIND_END};
            end else begin
               res      = '{valid: 1'b1, data: item.rx_byte, kind: KIND_DATA};
            end
         end else begin
            unique case (phase_ff)
               PH_LINE: begin
                  if (item.op == OP_TIMEOUT) begin
                     phase_in = PH_DONE;
                     res      = '{valid: 1'b1, data: 8'd0, kind: KIND_TRUNC};
                  end else if (item.rx_byte == CH_LF) begin
                     if (chars_ff == '0) begin
                        accum_in = '0;
                        chars_in = '0;
                        hx_in    = HX_SPACES;
                        phase_in = PH_LINE;
                     end else begin
                        left_in  = accum_ff;
                        skip_in  = 2'd2;
                        phase_in = (accum_ff == '0) ? PH_SKIP_END : PH_DATA;
                     end
                  end else if (item.rx_byte != CH_CR && chars_ff < LINE_MAX) begin
                     chars_in = chars_ff + LINE_W'(1);
                     unique case (hx_ff)
                        HX_SPACES: begin
                           if (is_blank(item.rx_byte)) begin
                              hx_in = HX_SPACES;
                           end else if (item.rx_byte == CH_ZERO) begin
                              hx_in = HX_ZERO;
                           end else if (!hd[4]) begin
                              hx_in = HX_DONE;
                           end else begin
                              accum_in = accum_add;
                              hx_in    = HX_DIGITS;
                           end
                        end
                        HX_ZERO: begin
                           if (item.rx_byte == CH_LX || item.rx_byte == CH_UX) begin
                              hx_in = HX_DIGITS;
                           end else if (!hd[4]) begin
                              hx_in = HX_DONE;
                           end else begin
                              accum_in = accum_add;
                              hx_in    = HX_DIGITS;
                           end
                        end
                        HX_DIGITS: begin
                           if (!hd[4]) begin
                              hx_in = HX_DONE;
                           end else begin
                              accum_in = accum_add;
                           end
                        end
                        default: begin
                           hx_in = HX_DONE;
                        end
                     endcase
                  end
               end
               PH_DATA: begin
                  if (item.op == OP_TIMEOUT) begin
                     phase_in = PH_DONE;
                     res      = '{valid: 1'b1, data: 8'd0, kind: KIND_TRUNC};
                  end else begin
                     left_in = left_dec;
                     if (left_dec == '0) begin
                        skip_in  = 2'd2;
                        phase_in = PH_SKIP_NEXT;
                     end
                     res = '{valid: 1'b1, data: item.rx_byte, kind: KIND_DATA};
                  end
               end
               PH_SKIP_NEXT: begin
                  skip_in = skip_dec;
                  if (skip_dec == 2'd0) begin
                     accum_in = '0;
                     chars_in = '0;
                     hx_in    = HX_SPACES;
                     phase_in = PH_LINE;
                  end
               end
               PH_SKIP_END: begin
                  skip_in = skip_dec;
                  if (skip_dec == 2'd0) begin
                     phase_in = PH_DONE;
                     res      = '{valid: 1'b1, data: 8'd0, kind: KIND_END};
                  end
               end
               default: begin
                  phase_in = PH_DONE;
               end
            endcase
         end
      end

      status.done = (phase_ff == PH_DONE);
   end

endmodule

`default_nettype wire
